>>> rtl/core/htbs_pkg.sv
// shared types, codes and defaults for the bucketed hash store
// used by htbs_ctrl, htbs_dpath and hash_table_bucketed_store; no dependencies
package htbs_pkg;

  // default geometry
  localparam int BUCKETS_DEF = 16;
  localparam int WAYS_DEF    = 4;

  // fixed field widths
  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 31;
  localparam int VAL_W    = 64;
  localparam int STATUS_W = 3;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  // request payload
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } in_t;

  // result payload
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    found_value;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;    // latch the request
    logic rd_in;     // read bucket row addressed by the incoming key
    logic rd_bkt;    // read bucket row addressed by the computed remainder
    logic mod_step;  // register the quotient of the reciprocal product
    logic clr_wr;    // clearing pass write
    logic exec;      // compare, write back and load the result
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;  // last row of the clearing pass
    logic out_busy;  // result register holds a result not taken this cycle
  } ctl_sts_t;

endpackage

>>> rtl/core/htbs_ctrl.sv
// controller state machine of the bucketed hash store
// depends on htbs_pkg for the command and status structs
module htbs_ctrl #(
  parameter int BUCKETS = htbs_pkg::BUCKETS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  htbs_pkg::ctl_sts_t  sts,
  output htbs_pkg::ctl_cmd_t  cmd
);

  localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam bit POW2 = ((1 << BW) == BUCKETS);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MOD   = 5'b00100,
    S_READ  = 5'b01000,
    S_EXEC  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          cmd.rd_in  = POW2;
          state_nxt  = POW2 ? S_EXEC : S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        state_nxt    = S_READ;
      end
      S_READ: begin
        cmd.rd_bkt = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        if (!sts.out_busy) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/htbs_dpath.sv
// datapath of the bucketed hash store: bucket memory, remainder unit,
// way compare and result register; depends on htbs_pkg
module htbs_dpath #(
  parameter int BUCKETS = htbs_pkg::BUCKETS_DEF,
  parameter int WAYS    = htbs_pkg::WAYS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  htbs_pkg::in_t       in_data,
  input  htbs_pkg::ctl_cmd_t  cmd,
  output htbs_pkg::ctl_sts_t  sts,
  output logic                out_valid,
  input  logic                out_ready,
  output htbs_pkg::out_t      out_data
);

  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam bit POW2  = ((1 << BW) == BUCKETS);
  localparam int KEY_W = htbs_pkg::KEY_W;
  localparam int VAL_W = htbs_pkg::VAL_W;

  // bucket rows: valid bits, keys and values of all ways
  logic [WAYS-1:0]             vld_mem [BUCKETS];
  logic [WAYS-1:0][KEY_W-1:0]  key_mem [BUCKETS];
  logic [WAYS-1:0][VAL_W-1:0]  val_mem [BUCKETS];

  logic [WAYS-1:0]             rd_vld_r;
  logic [WAYS-1:0][KEY_W-1:0]  rd_key_r;
  logic [WAYS-1:0][VAL_W-1:0]  rd_val_r;

  htbs_pkg::in_t  req_r;
  htbs_pkg::out_t out_r;
  logic           out_valid_r;
  logic [BW-1:0]  clr_r;
  logic [BW-1:0]  bkt;
  logic [BW-1:0]  rd_addr;
  logic [BW-1:0]  wr_addr;
  logic           rd_en;
  logic           vld_we;
  logic           kv_we;
  logic [WAYS-1:0] wr_vld;

  logic [WAYS-1:0]             hit_c;
  logic [WAYS-1:0]             free_c;
  logic [WAYS-1:0]             free1h_c;
  logic [VAL_W-1:0]            hit_val_c;
  logic [WAYS-1:0]             new_vld_c;
  logic [WAYS-1:0][KEY_W-1:0]  new_key_c;
  logic [WAYS-1:0][VAL_W-1:0]  new_val_c;
  logic                        vld_chg_c;
  logic                        kv_chg_c;
  htbs_pkg::out_t              res_c;

  // request register
  always_ff @(posedge clk) begin
    if (cmd.accept) req_r <= in_data;
  end

  // bucket index: low key bits, or the remainder by reciprocal multiplication
  generate
    if (POW2) begin : g_pow2
      assign bkt = req_r.key[BW-1:0];
    end else begin : g_mod
      // reciprocal of BUCKETS, exact quotient for every key of KEY_W bits
      localparam int MW = 33;
      localparam int SH = KEY_W + BW;
      localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
      logic [KEY_W+MW-1:0] prod_c;
      logic [BW-1:0]       q_lo_r;
      logic [BW-1:0]       qd_lo_c;

      // quotient from the reciprocal product, only its low bits are kept
      assign prod_c = (KEY_W+MW)'(req_r.key) * (KEY_W+MW)'(RECIP);

      always_ff @(posedge clk) begin
        if (cmd.mod_step) q_lo_r <= prod_c[SH +: BW];
      end

      // remainder is below BUCKETS, so its low bits are exact
      assign qd_lo_c = BW'(q_lo_r * BW'(BUCKETS));
      assign bkt     = req_r.key[BW-1:0] - qd_lo_c;
    end
  endgenerate

  // clearing pass row counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_r <= clr_r + BW'(1);
    end
  end

  assign sts.clr_last = (clr_r == BW'(BUCKETS - 1));

  // way compare and update of the row read
  always_comb begin
    hit_val_c = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_c[w] = rd_vld_r[w] && (rd_key_r[w] == req_r.key);
      if (hit_c[w]) hit_val_c = hit_val_c | rd_val_r[w];
    end
    free_c   = ~rd_vld_r;
    free1h_c = free_c & (~free_c + WAYS'(1));

    new_vld_c = rd_vld_r;
    new_key_c = rd_key_r;
    new_val_c = rd_val_r;
    vld_chg_c = 1'b0;
    kv_chg_c  = 1'b0;
    res_c.status      = htbs_pkg::ST_NOT_FOUND;
    res_c.found_value = '0;

    case (req_r.func)
      htbs_pkg::FUNC_INSERT: begin
        if (|hit_c) begin
          for (int w = 0; w < WAYS; w++) begin
            if (hit_c[w]) new_val_c[w] = req_r.value;
          end
          kv_chg_c     = 1'b1;
          res_c.status = htbs_pkg::ST_UPDATED;
        end else if (|free_c) begin
          for (int w = 0; w < WAYS; w++) begin
            if (free1h_c[w]) begin
              new_key_c[w] = req_r.key;
              new_val_c[w] = req_r.value;
            end
          end
          new_vld_c    = rd_vld_r | free1h_c;
          vld_chg_c    = 1'b1;
          kv_chg_c     = 1'b1;
          res_c.status = htbs_pkg::ST_INSERTED;
        end else begin
          res_c.status = htbs_pkg::ST_FULL;
        end
      end
      htbs_pkg::FUNC_REMOVE: begin
        if (|hit_c) begin
          new_vld_c    = rd_vld_r & ~hit_c;
          vld_chg_c    = 1'b1;
          res_c.status = htbs_pkg::ST_REMOVED;
        end
      end
      htbs_pkg::FUNC_SEARCH: begin
        if (|hit_c) begin
          res_c.status      = htbs_pkg::ST_FOUND;
          res_c.found_value = hit_val_c;
        end
      end
      default: ;
    endcase
  end

  // memory port control
  assign rd_en   = cmd.rd_in | cmd.rd_bkt;
  assign rd_addr = cmd.rd_in ? in_data.key[BW-1:0] : bkt;
  assign wr_addr = cmd.clr_wr ? clr_r : bkt;
  assign vld_we  = cmd.clr_wr | (cmd.exec & vld_chg_c);
  assign kv_we   = cmd.exec & kv_chg_c;
  assign wr_vld  = cmd.clr_wr ? '0 : new_vld_c;

  // bucket memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (vld_we) vld_mem[wr_addr] <= wr_vld;
    if (kv_we) begin
      key_mem[wr_addr] <= new_key_c;
      val_mem[wr_addr] <= new_val_c;
    end
    if (rd_en) begin
      rd_vld_r <= vld_mem[rd_addr];
      rd_key_r <= key_mem[rd_addr];
      rd_val_r <= val_mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) out_r <= res_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_busy = out_valid_r & ~out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule

>>> rtl/core/hash_table_bucketed_store.sv
// top level of the bucketed hash store: controller plus datapath
// depends on htbs_pkg, htbs_ctrl and htbs_dpath

// Key/value store of BUCKETS buckets with WAYS ways each; a key lives in
// bucket key mod BUCKETS. Each transaction inserts or updates, removes or
// searches and gives exactly one result. One transaction is in work at a
// time. With BUCKETS a power of two the bucket row is read from the row
// memory in the accept cycle, then compared over all ways and written back
// in the S_EXEC state that follows. Otherwise the bucket index comes from a
// reciprocal multiplication of the key, and a transaction goes through
// accept, quotient, row read, then compare and write-back. A finished
// result waits in an output register while the next transaction is taken;
// that transaction's write-back stalls for as long as the previous result
// is still held. After reset a clearing pass over all BUCKETS rows empties
// the table; in_ready stays low until it ends.
module hash_table_bucketed_store #(
  parameter int BUCKETS = htbs_pkg::BUCKETS_DEF,
  parameter int WAYS    = htbs_pkg::WAYS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  htbs_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output htbs_pkg::out_t  out_data
);

  htbs_pkg::ctl_cmd_t cmd;
  htbs_pkg::ctl_sts_t sts;

  // sequencing
  htbs_ctrl #(
    .BUCKETS (BUCKETS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and compare
  htbs_dpath #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // one transaction at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("transaction accepted while another is in work");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !(out_valid && !out_ready))
    else $error("result register overwritten before it was taken");

  // a finished transaction shows its result
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("result not presented after write-back");

  // clearing and lookup never share the memory port
  a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> !(cmd.exec || cmd.rd_in || cmd.rd_bkt || in_ready))
    else $error("clearing pass overlaps request processing");
`endif

endmodule

>>> tb/sv/tb_htbs_checker.sv
`timescale 1ns / 100ps
// result checker for the bucketed hash store: predicts each result from the
// accepted transactions and compares it with the block's output; needs htbs_pkg
module tb_htbs_checker #(
  parameter int BUCKETS = htbs_pkg::BUCKETS_DEF,
  parameter int WAYS    = htbs_pkg::WAYS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  htbs_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  htbs_pkg::out_t out_data,
  output int             mismatch_count,
  output int             results_owed
);
  import htbs_pkg::*;

  localparam int ENTRIES = BUCKETS * WAYS;

  // shadow copy of the table, way w of bucket b at b*WAYS+w
  logic             slot_used  [ENTRIES];
  logic [KEY_W-1:0] slot_key   [ENTRIES];
  logic [VAL_W-1:0] slot_value [ENTRIES];

  out_t owed_q[$];
  int   fail_total = 0;

  // apply one transaction to the shadow table and return its result
  function automatic out_t table_lookup_update(input in_t req);
    int   base;
    int   hit;
    int   spare;
    out_t res;
    base  = int'(req.key % BUCKETS) * WAYS;
    hit   = -1;
    spare = -1;
    // walk down so that the lowest free way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (slot_used[base + w] && slot_key[base + w] == req.key) hit = base + w;
      if (!slot_used[base + w]) spare = base + w;
    end
    res.status      = ST_NOT_FOUND;
    res.found_value = '0;
    case (req.func)
      FUNC_INSERT: begin
        if (hit >= 0) begin
          slot_value[hit] = req.value;
          res.status      = ST_UPDATED;
        end else if (spare >= 0) begin
          slot_used[spare]  = 1'b1;
          slot_key[spare]   = req.key;
          slot_value[spare] = req.value;
          res.status        = ST_INSERTED;
        end else begin
          res.status = ST_FULL;
        end
      end
      FUNC_REMOVE: begin
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          res.status     = ST_REMOVED;
        end
      end
      FUNC_SEARCH: begin
        if (hit >= 0) begin
          res.found_value = slot_value[hit];
          res.status      = ST_FOUND;
        end
      end
      default: begin
        // unused code leaves the table alone
      end
    endcase
    return res;
  endfunction

  // predict on each request transaction, compare on each result transaction
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
      owed_q.delete();
      fail_total = 0;
    end else begin
      if (in_valid && in_ready) owed_q.push_back(table_lookup_update(in_data));
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          if (fail_total < 10)
            $display("%0t: result with none owed: status %0d value %h",
                     $realtime, out_data.status, out_data.found_value);
          fail_total++;
        end else begin
          want = owed_q.pop_front();
          if (out_data.status !== want.status ||
              out_data.found_value !== want.found_value) begin
            if (fail_total < 10)
              $display("%0t: mismatch: expected status %0d value %h, got status %0d value %h",
                       $realtime, want.status, want.found_value,
                       out_data.status, out_data.found_value);
            fail_total++;
          end
        end
      end
    end
    mismatch_count <= fail_total;
    results_owed   <= owed_q.size();
  end

endmodule

>>> tb/sv/tb_hash_table_bucketed_store.sv
`timescale 1ns / 100ps
// top of the bucketed hash store testbench: clock, reset, request and stall
// generation and the verdict; needs htbs_pkg, hash_table_bucketed_store, tb_htbs_checker
module tb_hash_table_bucketed_store;
  import htbs_pkg::*;

  localparam int BUCKETS     = BUCKETS_DEF;
  localparam int WAYS        = WAYS_DEF;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1100;
  localparam int EPOCH        = 100;
  localparam int QUIET_TAIL   = 150;
  localparam int POOL_SIZE    = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int mismatch_count;
  int results_owed;
  int cycle_count = 0;
  int ready_hold  = 0;
  bit quiet       = 1'b0;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  hash_table_bucketed_store #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  tb_htbs_checker #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hash_table_bucketed_store regression: fail");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      ready_hold <= $urandom_range(0, 3);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [VAL_W-1:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  // random key that lands in one of three buckets starting at first_bucket
  function automatic logic [KEY_W-1:0] pool_key(input int first_bucket);
    longint k;
    k = longint'($urandom_range(0, 32'h7FFF_FFFF));
    return KEY_W'((k / BUCKETS) * BUCKETS + (first_bucket + $urandom_range(0, 2)) % BUCKETS);
  endfunction

  // present one request transaction, with an optional gap before it
  task automatic send_request(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data.func  <= func;
    in_data.key   <= key;
    in_data.value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    int                pick;
    int                first_bucket;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, each operation, overwrite, full bucket, way reuse
    send_request(FUNC_SEARCH, '0, '1);
    send_request(FUNC_INSERT, '0, '0);
    send_request(FUNC_INSERT, KEY_MAX, '1);
    send_request(FUNC_SEARCH, KEY_MAX, '0);
    send_request(FUNC_SEARCH, '0, '1);
    send_request(FUNC_INSERT, '0, 64'hA5A5_5A5A_0123_4567);
    send_request(FUNC_SEARCH, '0, '0);
    send_request(FUNC_INSERT, KEY_W'(BUCKETS), 64'h1);
    send_request(FUNC_INSERT, KEY_W'(2 * BUCKETS), 64'h2);
    send_request(FUNC_INSERT, KEY_W'(3 * BUCKETS), 64'h3);
    send_request(FUNC_INSERT, KEY_W'(4 * BUCKETS), 64'h4);
    send_request(FUNC_REMOVE, KEY_W'(BUCKETS), '0);
    send_request(FUNC_INSERT, KEY_W'(4 * BUCKETS), 64'hFFFF_0000_FFFF_0000);
    send_request(FUNC_SEARCH, KEY_W'(4 * BUCKETS), '0);
    send_request(FUNC_SEARCH, KEY_W'(BUCKETS), '0);
    send_request(FUNC_REMOVE, KEY_W'(BUCKETS), '0);
    send_request(FUNC_UNUSED, '0, '1);
    send_request(FUNC_REMOVE, KEY_MAX, '0);
    send_request(FUNC_SEARCH, KEY_MAX, '0);
    send_request(FUNC_INSERT, KEY_W'(32'h7FFF_FFFF / BUCKETS * BUCKETS), '1);
    send_request(FUNC_REMOVE, '0, '0);
    send_request(FUNC_REMOVE, KEY_W'(4 * BUCKETS), '0);
    send_request(FUNC_REMOVE, KEY_W'(2 * BUCKETS), '0);
    send_request(FUNC_REMOVE, KEY_W'(3 * BUCKETS), '0);

    // random: a small key set per epoch so buckets fill, hit and drain
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 400 && n < 480) || (n >= RANDOM_ITEMS - QUIET_TAIL);
      if (n % EPOCH == 0) begin
        first_bucket = $urandom_range(0, BUCKETS - 1);
        for (int p = 0; p < POOL_SIZE; p++) begin
          if (n != 0) send_request(FUNC_REMOVE, key_pool[p], rand_value());
          key_pool[p] = pool_key(first_bucket);
        end
      end
      // drain everything once before carrying on
      if (n == 600) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_owed != 0) @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) func = FUNC_INSERT;
      else if (pick < 65) func = FUNC_REMOVE;
      else if (pick < 95) func = FUNC_SEARCH;
      else func = FUNC_UNUSED;
      if ($urandom_range(0, 19) == 0) key = KEY_W'($urandom);
      else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_request(func, key, rand_value());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("hash_table_bucketed_store regression: pass");
    end else begin
      $display("hash_table_bucketed_store regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/htbs_pkg.sv
rtl/core/htbs_ctrl.sv
rtl/core/htbs_dpath.sv
rtl/core/hash_table_bucketed_store.sv
tb/sv/tb_htbs_checker.sv
tb/sv/tb_hash_table_bucketed_store.sv
